### design/jsd_pkg.sv
package jsd_pkg;

    // Decoder phase, one-hot
    typedef enum logic [6:0] {
        PH_BODY    = 7'b0000001,
        PH_CONT    = 7'b0000010,
        PH_ESC     = 7'b0000100,
        PH_HEX1    = 7'b0001000,
        PH_WANT_BS = 7'b0010000,
        PH_WANT_U  = 7'b0100000,
        PH_HEX2    = 7'b1000000
    } t_phase;

    // Status codes carried by each result
    typedef enum logic [3:0] {
        ST_CONT        = 4'd0,
        ST_CLOSED      = 4'd1,
        ST_UNTERM      = 4'd2,
        ST_TOO_LONG    = 4'd3,
        ST_CONTROL     = 4'd4,
        ST_BAD_LEAD    = 4'd5,
        ST_TRUNC_UTF8  = 4'd6,
        ST_BAD_CONT    = 4'd7,
        ST_UNTERM_ESC  = 4'd8,
        ST_UNKNOWN_ESC = 4'd9,
        ST_TRUNC_HEX   = 4'd10,
        ST_BAD_HEX     = 4'd11,
        ST_NUL         = 4'd12,
        ST_LONE_HIGH   = 4'd13,
        ST_BAD_LOW     = 4'd14,
        ST_LONE_LOW    = 4'd15
    } t_status;

    // One result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        t_status    status;
        logic       last;
    } t_result;

    // UTF-8 encoding of one code point
    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      n;
    } t_utf8;

    localparam int          MAX_RESULTS   = 4;
    localparam int          QUEUE_DEPTH   = 5;
    localparam logic [15:0] MAX_LEN_RESET = 16'd4096;
    localparam logic [16:0] LEN_SAT       = 17'h1FFFF;

    // Characters of interest
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [7:0] CONT_LO = 8'h80;
    localparam logic [7:0] CONT_HI = 8'hBF;

endpackage

### design/jsd_in_if.sv
interface jsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       input_ended;

    modport source (output valid, output in_byte, output input_ended, input ready);
    modport sink (input valid, input in_byte, input input_ended, output ready);
endinterface

### design/jsd_out_if.sv
interface jsd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [3:0] status;
    logic       last;

    modport source (output valid, output out_byte, output byte_valid, output status,
                    output last, input ready);
    modport sink (input valid, input out_byte, input byte_valid, input status,
                  input last, output ready);
endinterface

### design/json_string_decoder_top.sv
// The results of a byte are registered into the output queue on its input transfer.
// Throughput: one input byte per cycle while input is not stalled; a byte that yields k
//   results gives k output items, and input stalls while two or more results wait.
// Reset: synchronous, active low on i_rst_n; clears decoder state and the
//   result queue, and sets the length limit to 4096.
module json_string_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    jsd_in_if.sink      i_in,
    jsd_out_if.source   o_out
);

    jsd_pkg::t_result [3:0] res;
    logic [2:0]             res_cnt;
    logic                   can_load;
    logic                   accept;
    jsd_pkg::t_result       head;

    assign i_in.ready = can_load;
    assign accept     = i_in.valid && can_load;

    // Decode one byte per transfer
    jsd_step u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_in_byte     (i_in.in_byte),
        .i_input_ended (i_in.input_ended),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_res         (res),
        .o_res_cnt     (res_cnt)
    );

    // Queue results toward the output
    jsd_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_res      (res),
        .i_cnt      (res_cnt),
        .i_ready    (o_out.ready),
        .o_can_load (can_load),
        .o_valid    (o_out.valid),
        .o_head     (head)
    );

    assign o_out.out_byte   = head.out_byte;
    assign o_out.byte_valid = head.byte_valid;
    assign o_out.status     = head.status;
    assign o_out.last       = head.last;

    // End of input always yields a single ending result
    a_ended_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.input_ended) |-> (res_cnt == 3'd1 && !res[0].byte_valid &&
                                          res[0].status != jsd_pkg::ST_CONT && res[0].last))
        else $error("end of input did not give one ending result");

    // A data byte carries the continuing status; an ending result carries an ending status instead of a byte
    a_byte_xor_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.byte_valid == (o_out.status == jsd_pkg::ST_CONT)))
        else $error("byte_valid and status disagree");

    // Input stalls only while results are waiting
    a_stall_needs_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_out.valid)
        else $error("input stalled with empty output");

    // A transfer yields at most four results, and none if it only moved state
    a_result_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (res_cnt <= 3'd4))
        else $error("too many results for one byte");

endmodule

### design/jsd_step.sv
module jsd_step (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [7:0]                    i_in_byte,
    input  logic                          i_input_ended,
    input  logic                          i_cfg_wr_en,
    input  logic [15:0]                   i_cfg_wr_data,
    output jsd_pkg::t_result [3:0]        o_res,
    output logic [2:0]                    o_res_cnt
);

    jsd_pkg::t_phase r_phase, n_phase;
    logic [23:0] r_held, n_held;
    logic [2:0]  r_seq_len, n_seq_len;
    logic [2:0]  r_seq_pos, n_seq_pos;
    logic [7:0]  r_lo, n_lo;
    logic [7:0]  r_hi, n_hi;
    logic [15:0] r_cu, n_cu;
    logic [2:0]  r_hex_cnt, n_hex_cnt;
    logic [9:0]  r_hs, n_hs;
    logic [16:0] r_len, n_len;
    logic [15:0] r_max_len;

    logic            fin;
    jsd_pkg::t_status fin_st;
    logic [3:0][7:0] bytes;
    logic [2:0]      nb;
    logic [7:0]      lo_b, hi_b;
    logic [2:0]      pos_inc;
    logic [4:0]      hv;
    logic [15:0]     cu_new;
    logic [2:0]      hex_inc;
    jsd_pkg::t_utf8  enc;
    logic [17:0]     len_sum;

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = '0;
        if (c inside {[8'h30:8'h39]}) begin
            v = {1'b1, c[3:0]};
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            v = {1'b1, c[3:0] + 4'd9};
        end
        return v;
    endfunction

    function automatic jsd_pkg::t_utf8 utf8_enc(input logic [20:0] cp);
        jsd_pkg::t_utf8 u;
        u = '0;
        if (cp < 21'h80) begin
            u.b[0] = cp[7:0];
            u.n    = 3'd1;
        end else if (cp < 21'h800) begin
            u.b[0] = {3'b110, cp[10:6]};
            u.b[1] = {2'b10, cp[5:0]};
            u.n    = 3'd2;
        end else if (cp < 21'h10000) begin
            u.b[0] = {4'b1110, cp[15:12]};
            u.b[1] = {2'b10, cp[11:6]};
            u.b[2] = {2'b10, cp[5:0]};
            u.n    = 3'd3;
        end else begin
            u.b[0] = {5'b11110, cp[20:18]};
            u.b[1] = {2'b10, cp[17:12]};
            u.b[2] = {2'b10, cp[11:6]};
            u.b[3] = {2'b10, cp[5:0]};
            u.n    = 3'd4;
        end
        return u;
    endfunction

    // Decode one byte against the current phase
    always_comb begin
        n_phase   = r_phase;
        n_held    = r_held;
        n_seq_len = r_seq_len;
        n_seq_pos = r_seq_pos;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_cu      = r_cu;
        n_hex_cnt = r_hex_cnt;
        n_hs      = r_hs;
        fin       = 1'b0;
        fin_st    = jsd_pkg::ST_CONT;
        bytes     = '0;
        nb        = 3'd0;
        lo_b      = (r_seq_pos == 3'd1) ? r_lo : jsd_pkg::CONT_LO;
        hi_b      = (r_seq_pos == 3'd1) ? r_hi : jsd_pkg::CONT_HI;
        pos_inc   = r_seq_pos + 3'd1;
        hv        = hex_val(i_in_byte);
        cu_new    = {r_cu[11:0], hv[3:0]};
        hex_inc   = r_hex_cnt + 3'd1;
        enc       = '0;

        if (i_input_ended) begin
            fin = 1'b1;
            case (r_phase)
                jsd_pkg::PH_BODY:    fin_st = jsd_pkg::ST_UNTERM;
                jsd_pkg::PH_CONT:    fin_st = jsd_pkg::ST_TRUNC_UTF8;
                jsd_pkg::PH_ESC:     fin_st = jsd_pkg::ST_UNTERM_ESC;
                jsd_pkg::PH_WANT_BS: fin_st = jsd_pkg::ST_LONE_HIGH;
                jsd_pkg::PH_WANT_U:  fin_st = jsd_pkg::ST_LONE_HIGH;
                default:             fin_st = jsd_pkg::ST_TRUNC_HEX;
            endcase
        end else begin
            case (r_phase)
                jsd_pkg::PH_BODY: begin
                    if (r_len > {1'b0, r_max_len}) begin
                        fin    = 1'b1;
                        fin_st = jsd_pkg::ST_TOO_LONG;
                    end else if (i_in_byte == jsd_pkg::CH_QUOTE) begin
                        fin    = 1'b1;
                        fin_st = jsd_pkg::ST_CLOSED;
                    end else if (i_in_byte < jsd_pkg::CH_SPACE) begin
                        fin    = 1'b1;
                        fin_st = jsd_pkg::ST_CONTROL;
                    end else if (i_in_byte == jsd_pkg::CH_BSLASH) begin
                        n_phase = jsd_pkg::PH_ESC;
                    end else if (!i_in_byte[7]) begin
                        bytes[0] = i_in_byte;
                        nb       = 3'd1;
                    end else begin
                        n_lo = jsd_pkg::CONT_LO;
                        n_hi = jsd_pkg::CONT_HI;
                        if (i_in_byte inside {[8'hC2:8'hDF]}) begin
                            n_seq_len = 3'd2;
                        end else if (i_in_byte inside {[8'hE0:8'hEF]}) begin
                            n_seq_len = 3'd3;
                            if (i_in_byte == 8'hE0) n_lo = 8'hA0;
                            if (i_in_byte == 8'hED) n_hi = 8'h9F;
                        end else if (i_in_byte inside {[8'hF0:8'hF4]}) begin
                            n_seq_len = 3'd4;
                            if (i_in_byte == 8'hF0) n_lo = 8'h90;
                            if (i_in_byte == 8'hF4) n_hi = 8'h8F;
                        end else begin
                            fin    = 1'b1;
                            fin_st = jsd_pkg::ST_BAD_LEAD;
                        end
                        n_held    = {16'h0000, i_in_byte};
                        n_seq_pos = 3'd1;
                        n_phase   = jsd_pkg::PH_CONT;
                    end
                end
                jsd_pkg::PH_CONT: begin
                    if (i_in_byte < lo_b || i_in_byte > hi_b) begin
                        fin    = 1'b1;
                        fin_st = jsd_pkg::ST_BAD_CONT;
                    end else if (pos_inc < r_seq_len) begin
                        n_seq_pos = pos_inc;
                        n_held    = {r_held[15:0], i_in_byte};
                    end else begin
                        // Release the whole sequence
                        case (r_seq_len)
                            3'd2: begin
                                bytes[0] = r_held[7:0];
                                bytes[1] = i_in_byte;
                                nb       = 3'd2;
                            end
                            3'd3: begin
                                bytes[0] = r_held[15:8];
                                bytes[1] = r_held[7:0];
                                bytes[2] = i_in_byte;
                                nb       = 3'd3;
                            end
                            default: begin
                                bytes[0] = r_held[23:16];
                                bytes[1] = r_held[15:8];
                                bytes[2] = r_held[7:0];
                                bytes[3] = i_in_byte;
                                nb       = 3'd4;
                            end
                        endcase
                        n_held    = '0;
                        n_seq_len = '0;
                        n_seq_pos = '0;
                        n_lo      = jsd_pkg::CONT_LO;
                        n_hi      = jsd_pkg::CONT_HI;
                        n_phase   = jsd_pkg::PH_BODY;
                    end
                end
                jsd_pkg::PH_ESC: begin
                    n_phase = jsd_pkg::PH_BODY;
                    nb      = 3'd1;
                    case (i_in_byte)
                        jsd_pkg::CH_QUOTE:  bytes[0] = jsd_pkg::CH_QUOTE;
                        jsd_pkg::CH_BSLASH: bytes[0] = jsd_pkg::CH_BSLASH;
                        jsd_pkg::CH_SLASH:  bytes[0] = jsd_pkg::CH_SLASH;
                        jsd_pkg::CH_B:      bytes[0] = 8'h08;
                        jsd_pkg::CH_F:      bytes[0] = 8'h0C;
                        jsd_pkg::CH_N:      bytes[0] = 8'h0A;
                        jsd_pkg::CH_R:      bytes[0] = 8'h0D;
                        jsd_pkg::CH_T:      bytes[0] = 8'h09;
                        jsd_pkg::CH_U: begin
                            nb        = 3'd0;
                            n_cu      = '0;
                            n_hex_cnt = '0;
                            n_phase   = jsd_pkg::PH_HEX1;
                        end
                        default: begin
                            nb     = 3'd0;
                            fin    = 1'b1;
                            fin_st = jsd_pkg::ST_UNKNOWN_ESC;
                        end
                    endcase
                end
                jsd_pkg::PH_WANT_BS: begin
                    if (i_in_byte == jsd_pkg::CH_BSLASH) begin
                        n_phase = jsd_pkg::PH_WANT_U;
                    end else begin
                        fin    = 1'b1;
                        fin_st = jsd_pkg::ST_LONE_HIGH;
                    end
                end
                jsd_pkg::PH_WANT_U: begin
                    if (i_in_byte == jsd_pkg::CH_U) begin
                        n_cu      = '0;
                        n_hex_cnt = '0;
                        n_phase   = jsd_pkg::PH_HEX2;
                    end else begin
                        fin    = 1'b1;
                        fin_st = jsd_pkg::ST_LONE_HIGH;
                    end
                end
                jsd_pkg::PH_HEX1, jsd_pkg::PH_HEX2: begin
                    if (!hv[4]) begin
                        fin    = 1'b1;
                        fin_st = jsd_pkg::ST_BAD_HEX;
                    end else if (hex_inc < 3'd4) begin
                        n_cu      = cu_new;
                        n_hex_cnt = hex_inc;
                    end else begin
                        n_cu      = '0;
                        n_hex_cnt = '0;
                        if (r_phase == jsd_pkg::PH_HEX1) begin
                            if (cu_new == 16'h0000) begin
                                fin    = 1'b1;
                                fin_st = jsd_pkg::ST_NUL;
                            end else if (cu_new inside {[16'hD800:16'hDBFF]}) begin
                                n_hs    = cu_new[9:0];
                                n_phase = jsd_pkg::PH_WANT_BS;
                            end else if (cu_new inside {[16'hDC00:16'hDFFF]}) begin
                                fin    = 1'b1;
                                fin_st = jsd_pkg::ST_LONE_LOW;
                            end else begin
                                enc     = utf8_enc({5'd0, cu_new});
                                bytes   = enc.b;
                                nb      = enc.n;
                                n_phase = jsd_pkg::PH_BODY;
                            end
                        end else begin
                            if (!(cu_new inside {[16'hDC00:16'hDFFF]})) begin
                                fin    = 1'b1;
                                fin_st = jsd_pkg::ST_BAD_LOW;
                            end else begin
                                enc     = utf8_enc(21'h10000 + {1'b0, r_hs, cu_new[9:0]});
                                bytes   = enc.b;
                                nb      = enc.n;
                                n_hs    = '0;
                                n_phase = jsd_pkg::PH_BODY;
                            end
                        end
                    end
                end
                default: begin
                    fin    = 1'b1;
                    fin_st = jsd_pkg::ST_UNTERM;
                end
            endcase
        end

        // Grow the decoded length, saturating
        len_sum = {1'b0, r_len} + {15'd0, nb};
        n_len   = (len_sum > {1'b0, jsd_pkg::LEN_SAT}) ? jsd_pkg::LEN_SAT : len_sum[16:0];

        // Build the results
        o_res     = '0;
        o_res_cnt = nb;
        for (int i = 0; i < jsd_pkg::MAX_RESULTS; i++) begin
            o_res[i].out_byte   = bytes[i];
            o_res[i].byte_valid = (3'(i) < nb);
            o_res[i].status     = jsd_pkg::ST_CONT;
            o_res[i].last       = ((3'(i) + 3'd1) == nb);
        end

        // End of string: one status result, drop all decoding state (the length limit stays)
        if (fin) begin
            o_res           = '0;
            o_res[0].status = fin_st;
            o_res[0].last   = 1'b1;
            o_res_cnt       = 3'd1;
            n_phase         = jsd_pkg::PH_BODY;
            n_held          = '0;
            n_seq_len       = '0;
            n_seq_pos       = '0;
            n_lo            = jsd_pkg::CONT_LO;
            n_hi            = jsd_pkg::CONT_HI;
            n_cu            = '0;
            n_hex_cnt       = '0;
            n_hs            = '0;
            n_len           = '0;
        end
    end

    // Advance state on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= jsd_pkg::PH_BODY;
            r_held    <= '0;
            r_seq_len <= '0;
            r_seq_pos <= '0;
            r_lo      <= jsd_pkg::CONT_LO;
            r_hi      <= jsd_pkg::CONT_HI;
            r_cu      <= '0;
            r_hex_cnt <= '0;
            r_hs      <= '0;
            r_len     <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_held    <= n_held;
            r_seq_len <= n_seq_len;
            r_seq_pos <= n_seq_pos;
            r_lo      <= n_lo;
            r_hi      <= n_hi;
            r_cu      <= n_cu;
            r_hex_cnt <= n_hex_cnt;
            r_hs      <= n_hs;
            r_len     <= n_len;
        end
    end

    // Length limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= jsd_pkg::MAX_LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_len <= i_cfg_wr_data;
        end
    end

endmodule

### design/jsd_outq.sv
module jsd_outq (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  jsd_pkg::t_result [3:0] i_res,
    input  logic [2:0]             i_cnt,
    input  logic                   i_ready,
    output logic                   o_can_load,
    output logic                   o_valid,
    output jsd_pkg::t_result       o_head
);

    jsd_pkg::t_result r_buf [jsd_pkg::QUEUE_DEPTH];
    jsd_pkg::t_result n_buf [jsd_pkg::QUEUE_DEPTH];
    logic [2:0] r_cnt, n_cnt;
    logic       pop;

    assign o_valid    = (r_cnt != 3'd0);
    assign o_head     = r_buf[0];
    assign pop        = o_valid && i_ready;
    assign o_can_load = (r_cnt <= 3'd1);

    // Shift out the head on a transfer, append a new group behind what is left
    always_comb begin
        n_buf = r_buf;
        n_cnt = r_cnt;
        if (pop) begin
            for (int i = 0; i < jsd_pkg::QUEUE_DEPTH - 1; i++) begin
                n_buf[i] = r_buf[i + 1];
            end
            n_cnt = r_cnt - 3'd1;
        end
        if (i_load) begin
            for (int i = 0; i < jsd_pkg::MAX_RESULTS; i++) begin
                if (n_cnt == 3'd0) begin
                    n_buf[i] = i_res[i];
                end else begin
                    n_buf[i + 1] = i_res[i];
                end
            end
            n_cnt = n_cnt + i_cnt;
        end
    end

    // Hold the count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Hold the payload
    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

endmodule
